FILE: sv/tccc_pkg.sv
package tccc_pkg;

    // counter width; result fields stay 32 bits
    localparam int COUNT_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;
    typedef logic [OUT_WIDTH-1:0]   t_out_cnt;

    localparam t_cnt CNT_ZERO = '0;
    localparam t_cnt CNT_ONE  = t_cnt'(1);
    localparam t_cnt CNT_MAX  = '1;

    // ascii codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_QUEST   = 8'h3f;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_UC_A    = 8'h41;
    localparam logic [7:0] CH_UC_Z    = 8'h5a;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_BQUOTE  = 8'h60;
    localparam logic [7:0] CH_LC_A    = 8'h61;
    localparam logic [7:0] CH_LC_Z    = 8'h7a;
    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_TILDE   = 8'h7e;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        t_out_cnt total_chars;
        t_out_cnt alpha_chars;
        t_out_cnt upper_chars;
        t_out_cnt digit_chars;
        t_out_cnt punct_chars;
        t_out_cnt white_chars;
        t_out_cnt space_chars;
        t_out_cnt tab_chars;
        t_out_cnt line_count;
        t_out_cnt blank_lines;
        t_out_cnt sentence_count;
        t_out_cnt word_chars;
    } t_out;

    // saturating increment
    function automatic t_cnt sat_inc(input t_cnt c, input logic en);
        t_cnt r;
        r = c;
        if (en && (c != CNT_MAX)) begin
            r = c + CNT_ONE;
        end
        return r;
    endfunction

    // low result bits of a counter, zero extended when the counter is narrower
    function automatic t_out_cnt to_out(input t_cnt c);
        logic [OUT_WIDTH+COUNT_WIDTH-1:0] ext;
        ext = {{OUT_WIDTH{1'b0}}, c};
        return ext[OUT_WIDTH-1:0];
    endfunction

endpackage

FILE: sv/text_char_class_counter.sv
// text_char_class_counter: takes one text byte per word on the input channel, the last byte
// of a text flagged by last_byte, and sorts each byte into lower-case, upper-case, digit,
// sentence end (. ! ?), other ascii punctuation, space, tab, line break (lf or cr) or
// unclassified (everything else, all bytes above 127 included). Saturating counters track
// each class together with total bytes, lines (starting at one), blank lines and sentences;
// a sentence end counts only while all four byte-position flags (position mod 4) are set.
// Only the last byte of a text produces an output word, carrying every count including that
// byte, and the block then starts over from its reset state. A byte is taken every cycle
// unless the input is stalled: it lands in an input register, is then classified and
// updates all counters in a single pass, and a last byte loads the result register, which
// drives the count word onto the output. A waiting result stalls the input only
// when the next byte to be processed is itself a last byte.
module text_char_class_counter
    import tccc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    typedef enum logic [3:0] {
        CLS_LOWER,
        CLS_UPPER,
        CLS_DIGIT,
        CLS_SENT,
        CLS_PUNCT,
        CLS_SPACE,
        CLS_TAB,
        CLS_BREAK,
        CLS_NONE
    } t_cls;

    // input register
    logic r_in_vld;
    t_in  r_in;

    // text state
    logic [1:0] r_pos;
    logic [3:0] r_flags;
    logic       r_line_empty;
    t_cnt r_total_ctr, r_alpha_ctr, r_upper_ctr, r_digit_ctr, r_punct_ctr, r_white_ctr;
    t_cnt r_space_ctr, r_tab_ctr, r_line_ctr, r_blank_ctr, r_sent_ctr, r_word_ctr;

    // result register
    logic r_out_vld;
    t_out r_out;

    logic out_free;
    logic proc;
    logic in_acc;
    t_cls cls;
    logic [7:0] b;
    logic [3:0] pos_bit;

    logic [1:0] n_pos;
    logic [3:0] n_flags;
    logic       n_line_empty;
    t_cnt n_total_ctr, n_alpha_ctr, n_upper_ctr, n_digit_ctr, n_punct_ctr, n_white_ctr;
    t_cnt n_space_ctr, n_tab_ctr, n_line_ctr, n_blank_ctr, n_sent_ctr, n_word_ctr;

    // result slot is free when empty or drained this cycle
    assign out_free = !r_out_vld || !i_out_stall;
    // a non-last byte never needs the result slot
    assign proc     = r_in_vld && (!r_in.last_byte || out_free);
    assign o_in_stall = r_in_vld && !proc;
    assign in_acc   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign b       = r_in.char_byte;
    assign pos_bit = 4'b0001 << r_pos;

    // byte class
    always_comb begin
        priority if (b >= CH_LC_A && b <= CH_LC_Z) begin
            cls = CLS_LOWER;
        end else if (b >= CH_UC_A && b <= CH_UC_Z) begin
            cls = CLS_UPPER;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            cls = CLS_DIGIT;
        end else if (b == CH_DOT || b == CH_BANG || b == CH_QUEST) begin
            cls = CLS_SENT;
        end else if ((b >= CH_BANG && b <= CH_SLASH) || (b >= CH_COLON && b <= CH_AT) ||
                     (b >= CH_LBRACK && b <= CH_BQUOTE) ||
                     (b >= CH_LBRACE && b <= CH_TILDE)) begin
            cls = CLS_PUNCT;
        end else if (b == CH_SPACE) begin
            cls = CLS_SPACE;
        end else if (b == CH_TAB) begin
            cls = CLS_TAB;
        end else if (b == CH_LF || b == CH_CR) begin
            cls = CLS_BREAK;
        end else begin
            cls = CLS_NONE;
        end
    end

    // counter and flag update for the byte in the input register
    always_comb begin
        n_pos       = r_pos + 2'd1;
        n_total_ctr = sat_inc(r_total_ctr, 1'b1);
        n_alpha_ctr = sat_inc(r_alpha_ctr, cls == CLS_LOWER || cls == CLS_UPPER);
        n_upper_ctr = sat_inc(r_upper_ctr, cls == CLS_UPPER);
        n_digit_ctr = sat_inc(r_digit_ctr, cls == CLS_DIGIT);
        // running letters plus digits, same as the saturated sum of the two
        n_word_ctr  = sat_inc(r_word_ctr,
                              cls == CLS_LOWER || cls == CLS_UPPER || cls == CLS_DIGIT);
        n_punct_ctr = sat_inc(r_punct_ctr, cls == CLS_SENT || cls == CLS_PUNCT);
        n_white_ctr = sat_inc(r_white_ctr,
                              cls == CLS_SPACE || cls == CLS_TAB || cls == CLS_BREAK);
        n_space_ctr = sat_inc(r_space_ctr, cls == CLS_SPACE);
        n_tab_ctr   = sat_inc(r_tab_ctr, cls == CLS_TAB);
        n_line_ctr  = sat_inc(r_line_ctr, cls == CLS_BREAK);
        n_blank_ctr = sat_inc(r_blank_ctr, cls == CLS_BREAK && r_line_empty);
        n_sent_ctr  = sat_inc(r_sent_ctr, cls == CLS_SENT && r_flags == 4'hf);

        unique case (cls)
            CLS_NONE: begin
                n_flags      = r_flags;
                n_line_empty = r_line_empty;
            end
            CLS_SENT: begin
                n_flags      = r_flags & ~pos_bit;
                n_line_empty = 1'b0;
            end
            CLS_BREAK: begin
                n_flags      = r_flags | pos_bit;
                n_line_empty = 1'b1;
            end
            default: begin
                n_flags      = r_flags | pos_bit;
                n_line_empty = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_pos        <= '0;
            r_flags      <= '0;
            r_line_empty <= 1'b1;
            r_total_ctr  <= CNT_ZERO;
            r_alpha_ctr  <= CNT_ZERO;
            r_upper_ctr  <= CNT_ZERO;
            r_digit_ctr  <= CNT_ZERO;
            r_punct_ctr  <= CNT_ZERO;
            r_white_ctr  <= CNT_ZERO;
            r_space_ctr  <= CNT_ZERO;
            r_tab_ctr    <= CNT_ZERO;
            r_line_ctr   <= CNT_ONE;
            r_blank_ctr  <= CNT_ZERO;
            r_sent_ctr   <= CNT_ZERO;
            r_word_ctr   <= CNT_ZERO;
        end else begin
            // input register
            if (in_acc) begin
                r_in_vld <= 1'b1;
                r_in     <= i_in_data;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end

            // result register: a last byte reloads it, otherwise it drains
            if (proc && r_in.last_byte) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            if (proc) begin
                if (r_in.last_byte) begin
                    r_out.total_chars         <= to_out(n_total_ctr);
                    r_out.alpha_chars         <= to_out(n_alpha_ctr);
                    r_out.upper_chars         <= to_out(n_upper_ctr);
                    r_out.digit_chars         <= to_out(n_digit_ctr);
                    r_out.punct_chars         <= to_out(n_punct_ctr);
                    r_out.white_chars         <= to_out(n_white_ctr);
                    r_out.space_chars         <= to_out(n_space_ctr);
                    r_out.tab_chars           <= to_out(n_tab_ctr);
                    r_out.line_count          <= to_out(n_line_ctr);
                    r_out.blank_lines         <= to_out(n_blank_ctr);
                    r_out.sentence_count      <= to_out(n_sent_ctr);
                    r_out.word_chars          <= to_out(n_word_ctr);
                    // start the next text from scratch
                    r_pos        <= '0;
                    r_flags      <= '0;
                    r_line_empty <= 1'b1;
                    r_total_ctr  <= CNT_ZERO;
                    r_alpha_ctr  <= CNT_ZERO;
                    r_upper_ctr  <= CNT_ZERO;
                    r_digit_ctr  <= CNT_ZERO;
                    r_punct_ctr  <= CNT_ZERO;
                    r_white_ctr  <= CNT_ZERO;
                    r_space_ctr  <= CNT_ZERO;
                    r_tab_ctr    <= CNT_ZERO;
                    r_line_ctr   <= CNT_ONE;
                    r_blank_ctr  <= CNT_ZERO;
                    r_sent_ctr   <= CNT_ZERO;
                    r_word_ctr   <= CNT_ZERO;
                end else begin
                    r_pos        <= n_pos;
                    r_flags      <= n_flags;
                    r_line_empty <= n_line_empty;
                    r_total_ctr  <= n_total_ctr;
                    r_alpha_ctr  <= n_alpha_ctr;
                    r_upper_ctr  <= n_upper_ctr;
                    r_digit_ctr  <= n_digit_ctr;
                    r_punct_ctr  <= n_punct_ctr;
                    r_white_ctr  <= n_white_ctr;
                    r_space_ctr  <= n_space_ctr;
                    r_tab_ctr    <= n_tab_ctr;
                    r_line_ctr   <= n_line_ctr;
                    r_blank_ctr  <= n_blank_ctr;
                    r_sent_ctr   <= n_sent_ctr;
                    r_word_ctr   <= n_word_ctr;
                end
            end
        end
    end

    // line count starts at one and never wraps
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_ctr != CNT_ZERO)
        else $error("line counter reached zero");

    // letters plus digits never fall behind letters alone or digits alone
    a_word_ge_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_ctr >= r_alpha_ctr && r_word_ctr >= r_digit_ctr)
        else $error("word counter behind its parts");

    // a last byte leaves the text state cleared
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.last_byte |=> r_total_ctr == CNT_ZERO && r_pos == 2'd0 &&
        r_flags == 4'h0 && r_line_empty)
        else $error("state not cleared after last byte");

    // a result word only appears after a last byte was processed
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(proc && r_in.last_byte))
        else $error("result word without a last byte");

    // a pending last byte never overwrites a result that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_out_stall |-> !(proc && r_in.last_byte))
        else $error("stalled result overwritten");

endmodule

FILE: sim/tb_top.sv
module tb_top;
    import tccc_pkg::*;

    // run shape
    localparam int RESET_CYCLES  = 9;
    localparam int PHASE_BYTES   = 265;
    localparam int SQUEEZE_BYTES = 60;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    // byte classes, same split as the block uses
    typedef enum logic [3:0] {
        CLS_LOWER,
        CLS_UPPER,
        CLS_DIGIT,
        CLS_STOP,
        CLS_PUNCT,
        CLS_SPACE,
        CLS_TAB,
        CLS_BREAK,
        CLS_NONE
    } char_class_e;

    // scoreboard: runs the counting rules on every accepted byte word and
    // queues the count word that a last byte produces
    class char_count_scoreboard;
        t_cnt n_total, n_alpha, n_upper, n_digit, n_punct, n_white;
        t_cnt n_space, n_tab, n_line, n_blank, n_sentence;
        logic [1:0] pos;
        logic [3:0] flags;
        logic       line_blank;
        t_out       expected_q[$];
        int         mismatches;
        int         words_checked;

        function new();
            mismatches    = 0;
            words_checked = 0;
            clear_counts();
        endfunction

        function void clear_counts();
            n_total    = '0;
            n_alpha    = '0;
            n_upper    = '0;
            n_digit    = '0;
            n_punct    = '0;
            n_white    = '0;
            n_space    = '0;
            n_tab      = '0;
            n_line     = t_cnt'(1);
            n_blank    = '0;
            n_sentence = '0;
            pos        = 2'd0;
            flags      = 4'h0;
            line_blank = 1'b1;
        endfunction

        // saturating step
        function t_cnt plus_one(t_cnt c);
            return (c == CNT_MAX) ? c : c + t_cnt'(1);
        endfunction

        function char_class_e class_of(logic [7:0] b);
            if (b >= CH_LC_A && b <= CH_LC_Z) return CLS_LOWER;
            if (b >= CH_UC_A && b <= CH_UC_Z) return CLS_UPPER;
            if (b >= CH_ZERO && b <= CH_NINE) return CLS_DIGIT;
            if (b == CH_DOT || b == CH_BANG || b == CH_QUEST) return CLS_STOP;
            if ((b >= CH_BANG && b <= CH_SLASH) || (b >= CH_COLON && b <= CH_AT) ||
                (b >= CH_LBRACK && b <= CH_BQUOTE) || (b >= CH_LBRACE && b <= CH_TILDE))
                return CLS_PUNCT;
            if (b == CH_SPACE) return CLS_SPACE;
            if (b == CH_TAB) return CLS_TAB;
            if (b == CH_LF || b == CH_CR) return CLS_BREAK;
            return CLS_NONE;
        endfunction

        function void note_byte(t_in w);
            char_class_e          cls;
            logic [3:0]           slot;
            logic [COUNT_WIDTH:0] word_sum;
            t_cnt                 n_word;
            t_out                 res;
            cls  = class_of(w.char_byte);
            slot = 4'b0001 << pos;
            n_total = plus_one(n_total);
            case (cls)
                CLS_LOWER: begin
                    n_alpha = plus_one(n_alpha);
                end
                CLS_UPPER: begin
                    n_alpha = plus_one(n_alpha);
                    n_upper = plus_one(n_upper);
                end
                CLS_DIGIT: begin
                    n_digit = plus_one(n_digit);
                end
                CLS_STOP: begin
                    n_punct = plus_one(n_punct);
                    // a sentence only counts with all four position flags up
                    if (flags == 4'hf) n_sentence = plus_one(n_sentence);
                end
                CLS_PUNCT: begin
                    n_punct = plus_one(n_punct);
                end
                CLS_SPACE: begin
                    n_white = plus_one(n_white);
                    n_space = plus_one(n_space);
                end
                CLS_TAB: begin
                    n_white = plus_one(n_white);
                    n_tab   = plus_one(n_tab);
                end
                CLS_BREAK: begin
                    n_white = plus_one(n_white);
                    n_line  = plus_one(n_line);
                    if (line_blank) n_blank = plus_one(n_blank);
                end
                default: begin
                end
            endcase
            // unclassified bytes leave flags and line state alone
            if (cls != CLS_NONE) begin
                line_blank = (cls == CLS_BREAK);
                flags      = (cls == CLS_STOP) ? (flags & ~slot) : (flags | slot);
            end
            pos = pos + 2'd1;
            if (w.last_byte) begin
                word_sum = {1'b0, n_alpha} + {1'b0, n_digit};
                n_word   = word_sum[COUNT_WIDTH] ? CNT_MAX : word_sum[COUNT_WIDTH-1:0];
                res.total_chars    = t_out_cnt'(n_total);
                res.alpha_chars    = t_out_cnt'(n_alpha);
                res.upper_chars    = t_out_cnt'(n_upper);
                res.digit_chars    = t_out_cnt'(n_digit);
                res.punct_chars    = t_out_cnt'(n_punct);
                res.white_chars    = t_out_cnt'(n_white);
                res.space_chars    = t_out_cnt'(n_space);
                res.tab_chars      = t_out_cnt'(n_tab);
                res.line_count     = t_out_cnt'(n_line);
                res.blank_lines    = t_out_cnt'(n_blank);
                res.sentence_count = t_out_cnt'(n_sentence);
                res.word_chars     = t_out_cnt'(n_word);
                expected_q.push_back(res);
                clear_counts();
            end
        endfunction

        function void compare_field(string name, t_out_cnt want, t_out_cnt got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("count word %0d, %s: expected %0d, got %0d",
                             words_checked, name, want, got);
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("count word with nothing expected: total_chars %0d",
                             got.total_chars);
                return;
            end
            want = expected_q.pop_front();
            compare_field("total_chars", want.total_chars, got.total_chars);
            compare_field("alpha_chars", want.alpha_chars, got.alpha_chars);
            compare_field("upper_chars", want.upper_chars, got.upper_chars);
            compare_field("digit_chars", want.digit_chars, got.digit_chars);
            compare_field("punct_chars", want.punct_chars, got.punct_chars);
            compare_field("white_chars", want.white_chars, got.white_chars);
            compare_field("space_chars", want.space_chars, got.space_chars);
            compare_field("tab_chars", want.tab_chars, got.tab_chars);
            compare_field("line_count", want.line_count, got.line_count);
            compare_field("blank_lines", want.blank_lines, got.blank_lines);
            compare_field("sentence_count", want.sentence_count, got.sentence_count);
            compare_field("word_chars", want.word_chars, got.word_chars);
            words_checked++;
        endfunction
    endclass

    // dut connections, all inputs known from time zero
    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    char_count_scoreboard sb = new();

    // traffic knobs, percent per cycle
    int idle_pct  = 0;
    int stall_pct = 0;
    int bytes_sent = 0;

    // long receiver hold-off, requested by the stimulus, counted by the receiver
    bit hold_go   = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    int watchdog_cycles = 0;

    logic [7:0] directed_text [0:23];

    text_char_class_counter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: checks every accepted count word, then picks next cycle's stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if (hold_go && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // hang guard
    initial begin
        while (watchdog_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            watchdog_cycles++;
        end
        $display("text_char_class_counter regression: fail");
        $finish;
    end

    // one byte word: optional idle cycles, then hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in w;
        w.char_byte = b;
        w.last_byte = last;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_byte(w);
        bytes_sent++;
    endtask

    // text shaped like prose: words, spaces, sentence ends and line breaks,
    // with runs of breaks for blank lines and a little raw byte noise
    task automatic send_text(input int len);
        logic [7:0] b;
        int         r;
        logic       prev_break;
        prev_break = 1'b0;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (prev_break && ($urandom_range(3) == 0)) begin
                b = ($urandom_range(1) != 0) ? CH_LF : CH_CR;
            end else if (r < 36) begin
                b = 8'($urandom_range(CH_LC_Z, CH_LC_A));
            end else if (r < 44) begin
                b = 8'($urandom_range(CH_UC_Z, CH_UC_A));
            end else if (r < 52) begin
                b = 8'($urandom_range(CH_NINE, CH_ZERO));
            end else if (r < 66) begin
                b = CH_SPACE;
            end else if (r < 72) begin
                case ($urandom_range(2))
                    0: b = CH_DOT;
                    1: b = CH_BANG;
                    default: b = CH_QUEST;
                endcase
            end else if (r < 79) begin
                case ($urandom_range(3))
                    0: b = 8'($urandom_range(CH_SLASH, CH_BANG));
                    1: b = 8'($urandom_range(CH_AT, CH_COLON));
                    2: b = 8'($urandom_range(CH_BQUOTE, CH_LBRACK));
                    default: b = 8'($urandom_range(CH_TILDE, CH_LBRACE));
                endcase
            end else if (r < 83) begin
                b = CH_TAB;
            end else if (r < 93) begin
                b = ($urandom_range(1) != 0) ? CH_LF : CH_CR;
            end else begin
                b = 8'($urandom_range(255));
            end
            prev_break = (b == CH_LF || b == CH_CR);
            send_byte(b, i == len - 1);
        end
    endtask

    // stop offering and wait for every queued count word
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int phase_start;

        // leading breaks give blank lines, then all four flags set before the
        // first dot, a second sentence end right after with its slot cleared,
        // and every class boundary plus unclassified low, del and high bytes
        directed_text = '{CH_LF, CH_CR, CH_UC_A, CH_LC_Z, CH_ZERO, CH_SPACE,
                          CH_DOT, CH_QUEST, CH_TAB, CH_BANG, CH_SLASH, CH_NINE,
                          CH_COLON, CH_AT, CH_UC_Z, CH_LBRACK, CH_BQUOTE, CH_LC_A,
                          CH_LBRACE, CH_TILDE, 8'h00, 8'h7f, 8'h80, 8'hff};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 24; i++) send_byte(directed_text[i], i == 23);
        // one-byte text made of a lone line break
        send_byte(CH_LF, 1'b1);
        wait_drained();

        // traffic phases: free flow, sparse sender, busy receiver, light both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                send_text(($urandom_range(24) == 0) ? $urandom_range(150, 60)
                                                    : $urandom_range(24, 1));
            end
            wait_drained();
        end

        // receiver holds off while short texts keep coming, so count words
        // pile up and the block stalls its input
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1'b1;
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < SQUEEZE_BYTES) send_text($urandom_range(3, 1));
        wait_drained();

        // nothing more may show up after the queue is empty
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("text_char_class_counter regression: pass");
        end else begin
            $display("text_char_class_counter regression: fail");
        end
        $finish;
    end

endmodule
